>>> hdl/knn_match_counter_defines.svh
// knn_match_counter_defines.svh: assertion macros for the match counter.
// Used by knn_match_counter.sv; no other dependencies.
`ifndef KNN_MATCH_COUNTER_DEFINES_SVH
`define KNN_MATCH_COUNTER_DEFINES_SVH

// assert that a implies b on the same edge
`define KNN_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// assert that a implies b on the next edge
`define KNN_ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

>>> hdl/knn_pkg.sv
// knn_pkg.sv: modes, status codes and state encoding for the match counter.
// No dependencies.
package knn_pkg;
    localparam int FEAT_W  = 16;
    localparam int LABEL_W = 8;
    localparam int CNT_W   = 4;

    typedef enum logic [1:0] {
        MODE_CLEAR = 2'd0,
        MODE_LOAD  = 2'd1,
        MODE_QUERY = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_RELABEL = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    // one-hot sequencer states
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_READ  = 6'b000010,
        S_DIST  = 6'b000100,
        S_INS   = 6'b001000,
        S_COUNT = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;
endpackage

>>> hdl/knn_ram.sv
// knn_ram.sv: generic single-port RAM with registered read.
// No dependencies.
module knn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

>>> hdl/knn_match_counter.sv
// knn_match_counter.sv: k-nearest-neighbor match counter, top level.
// Depends on knn_pkg, knn_ram and knn_match_counter_defines.svh.
//
//  channel   signals                                   handshake
//  input     i_mode, i_feature_0..3, i_class_label     i_start & !o_busy
//  result    o_match_count, o_found_count, o_status    o_done, one cycle
//  config    i_cfg_data (neighbor_count)               i_cfg_we
//
// Clear, unused mode and query with k of zero go straight to S_DONE. Load and
// query scan the store through one RAM port and one squaring unit, an S_READ
// step and then one S_DIST step per feature for each stored point; a load
// then ends in S_DONE. A query walks S_INS per point not skipped, then runs
// S_COUNT over found entries; o_done follows. o_busy stays high through o_done.
// Reset clears the store count and sets k to 3; the receiver cannot stall.
`include "knn_match_counter_defines.svh"
module knn_match_counter #(
    parameter int FEATURES = 4,
    parameter int ENTRIES  = 256,
    parameter int K_MAX    = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [1:0]                    i_mode,
    input  logic signed [15:0]            i_feature_0,
    input  logic signed [15:0]            i_feature_1,
    input  logic signed [15:0]            i_feature_2,
    input  logic signed [15:0]            i_feature_3,
    input  logic [7:0]                    i_class_label,
    input  logic                          i_cfg_we,
    input  logic [3:0]                    i_cfg_data,
    output logic                          o_done,
    output logic [3:0]                    o_match_count,
    output logic [3:0]                    o_found_count,
    output logic [1:0]                    o_status
);
    import knn_pkg::*;

    localparam int AW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int NW    = $clog2(ENTRIES + 1);
    localparam int VW    = FEATURES * FEAT_W;
    localparam int FW    = (FEATURES > 1) ? $clog2(FEATURES) : 1;
    localparam int FCW   = $clog2(FEATURES + 1);
    localparam int DW    = 2 * (FEAT_W + 1) + $clog2(FEATURES + 1);
    localparam int KW    = (K_MAX > 1) ? $clog2(K_MAX) : 1;
    localparam int KCW   = $clog2(K_MAX + 1);

    // request registers
    t_state                r_state;
    logic [1:0]            r_mode;
    logic [VW-1:0]         r_vec;
    logic [LABEL_W-1:0]    r_label;
    logic [CNT_W-1:0]      r_k_cfg;
    logic [KCW-1:0]        r_k;
    logic [NW-1:0]         r_stored;
    logic [NW-1:0]         r_idx;
    logic [FCW-1:0]        r_fidx;
    logic [DW-1:0]         r_acc;
    logic                  r_same;
    logic [KCW-1:0]        r_found;
    logic [KCW-1:0]        r_pos;
    logic [KCW-1:0]        r_cnt;
    logic [CNT_W-1:0]      r_match;
    logic [1:0]            r_status;
    logic                  r_done;
    logic [DW-1:0]         r_bd [K_MAX];
    logic [LABEL_W-1:0]    r_bl [K_MAX];

    // RAM ports
    logic                  ram_we;
    logic [AW-1:0]         ram_addr;
    logic [VW-1:0]         ram_vec;
    logic [LABEL_W-1:0]    ram_lab;
    logic [VW-1:0]         wr_vec;

    knn_ram #(.WIDTH(VW), .DEPTH(ENTRIES)) u_feat (
        .i_clk(i_clk), .i_we(ram_we && r_mode == MODE_LOAD && !r_same),
        .i_addr(ram_addr), .i_wdata(wr_vec), .o_rdata(ram_vec));
    knn_ram #(.WIDTH(LABEL_W), .DEPTH(ENTRIES)) u_lab (
        .i_clk(i_clk), .i_we(ram_we), .i_addr(ram_addr),
        .i_wdata(r_label), .o_rdata(ram_lab));

    assign wr_vec   = r_vec;
    assign ram_addr = r_idx[AW-1:0];

    // input vector assembly, extra features zero
    logic [VW-1:0] in_vec;
    always_comb begin
        in_vec = '0;
        for (int f = 0; f < FEATURES; f++) begin
            case (f)
                0: in_vec[f*FEAT_W +: FEAT_W] = i_feature_0;
                1: in_vec[f*FEAT_W +: FEAT_W] = i_feature_1;
                2: in_vec[f*FEAT_W +: FEAT_W] = i_feature_2;
                3: in_vec[f*FEAT_W +: FEAT_W] = i_feature_3;
                default: in_vec[f*FEAT_W +: FEAT_W] = '0;
            endcase
        end
    end

    // shared distance unit: one feature squared per cycle
    logic signed [FEAT_W-1:0] fa, fb;
    logic signed [FEAT_W:0]   fdiff;
    logic [FEAT_W:0]          fmag;
    logic [2*FEAT_W+1:0]      fsq;
    always_comb begin
        fa    = ram_vec[r_fidx[FW-1:0]*FEAT_W +: FEAT_W];
        fb    = r_vec[r_fidx[FW-1:0]*FEAT_W +: FEAT_W];
        fdiff = {fa[FEAT_W-1], fa} - {fb[FEAT_W-1], fb};
        fmag  = fdiff[FEAT_W] ? (FEAT_W+1)'(-fdiff) : fdiff;
        fsq   = fmag * fmag;
    end

    // insertion compare: previous slot distance above new distance
    logic [KW-1:0] pm1;
    logic          shift_up;
    assign pm1      = KW'(r_pos - 1'b1);
    assign shift_up = (r_pos != '0) && (r_bd[pm1] > r_acc);

    logic [KCW-1:0] k_sat;
    assign k_sat = (r_k_cfg > K_MAX) ? KCW'(K_MAX) : KCW'(r_k_cfg);

    logic scan_end;
    assign scan_end = (r_idx >= r_stored);

    always_comb begin
        ram_we = 1'b0;
        if (r_state == S_DONE && r_mode == MODE_LOAD && r_status != ST_FULL) begin
            ram_we = 1'b1;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_stored <= '0;
            r_k_cfg  <= CNT_W'(3);
            r_done   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_we) begin
                r_k_cfg <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_start && !o_busy) begin
                        r_mode   <= i_mode;
                        r_vec    <= in_vec;
                        r_label  <= i_class_label;
                        r_k      <= k_sat;
                        r_idx    <= '0;
                        r_found  <= '0;
                        r_match  <= '0;
                        r_status <= ST_OK;
                        r_same   <= 1'b0;
                        if (i_mode == MODE_LOAD || (i_mode == MODE_QUERY && k_sat != '0)) begin
                            r_state <= S_READ;
                        end else begin
                            if (i_mode == MODE_CLEAR) begin
                                r_stored <= '0;
                            end
                            r_state <= S_DONE;
                        end
                    end
                end
                S_READ: begin
                    // RAM read issued at r_idx; data next cycle
                    if (scan_end) begin
                        if (r_mode == MODE_LOAD) begin
                            if (r_stored >= NW'(ENTRIES)) begin
                                r_status <= ST_FULL;
                            end
                            r_state <= S_DONE;
                        end else begin
                            r_cnt   <= '0;
                            r_state <= S_COUNT;
                        end
                    end else begin
                        r_fidx  <= '0;
                        r_acc   <= '0;
                        r_state <= S_DIST;
                    end
                end
                S_DIST: begin
                    r_acc  <= r_acc + DW'(fsq);
                    r_fidx <= r_fidx + 1'b1;
                    if (r_fidx == FCW'(FEATURES - 1)) begin
                        if (ram_vec == r_vec) begin
                            if (r_mode == MODE_LOAD) begin
                                r_same   <= 1'b1;
                                r_status <= ST_RELABEL;
                                r_state  <= S_DONE;
                            end else begin
                                r_idx   <= r_idx + 1'b1;
                                r_state <= S_READ;
                            end
                        end else if (r_mode == MODE_LOAD) begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_READ;
                        end else begin
                            r_pos   <= r_found;
                            r_state <= S_INS;
                        end
                    end
                end
                S_INS: begin
                    // walk down one slot per cycle, shifting larger entries up
                    if (shift_up) begin
                        if (r_pos < r_k) begin
                            r_bd[r_pos[KW-1:0]] <= r_bd[pm1];
                            r_bl[r_pos[KW-1:0]] <= r_bl[pm1];
                        end
                        r_pos <= r_pos - 1'b1;
                    end else begin
                        if (r_pos < r_k) begin
                            r_bd[r_pos[KW-1:0]] <= r_acc;
                            r_bl[r_pos[KW-1:0]] <= ram_lab;
                            if (r_found < r_k) begin
                                r_found <= r_found + 1'b1;
                            end
                        end
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_READ;
                    end
                end
                S_COUNT: begin
                    if (r_cnt >= r_found) begin
                        r_state <= S_DONE;
                    end else begin
                        if (r_bl[r_cnt[KW-1:0]] == r_label) begin
                            r_match <= r_match + 1'b1;
                        end
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DONE: begin
                    if (ram_we && !r_same) begin
                        r_stored <= r_stored + 1'b1;
                    end
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result word
    assign o_busy        = (r_state != S_IDLE) || r_done;
    assign o_done        = r_done;
    assign o_match_count = r_match;
    assign o_found_count = CNT_W'(r_found);
    assign o_status      = r_status;

    `KNN_ASSERT_IMP(a_found_le_k, i_clk, i_rst_n, r_state != S_IDLE, r_found <= r_k)
    `KNN_ASSERT_IMP(a_stored_max, i_clk, i_rst_n, 1'b1, r_stored <= NW'(ENTRIES))
    `KNN_ASSERT_NXT(a_done_pulse, i_clk, i_rst_n, r_state == S_DONE, o_done)
    `KNN_ASSERT_IMP(a_match_le_found, i_clk, i_rst_n, o_done, o_match_count <= o_found_count)
endmodule
